// ----- rtl/core/mgsa_pkg.sv -----
`timescale 1ns / 1ps

package mgsa_pkg;

  localparam int IdxW = 10;
  localparam int CfgW = 11;
  localparam logic [CfgW-1:0] RoomReset = 11'd1024;

  typedef enum logic [0:0] {
    REQ_TAKE    = 1'b0,
    REQ_RELEASE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_REL = 2'd2
  } status_e;

  typedef struct packed {
    req_e            req_type;
    logic [IdxW-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] given_slot;
    status_e         status;
  } res_t;

  typedef struct packed {
    logic    accept;
    logic    clr_start;
    logic    clr_step;
    logic    scan_issue;
    logic    loc_start;
    logic    wr_en;
    logic    res_valid;
    status_e res_code;
  } cmd_t;

  typedef struct packed {
    logic word_last;
    logic pipe_empty;
    logic none;
    logic rel_bad;
    logic bit_set;
    logic is_take;
  } sts_t;

endpackage

// ----- rtl/core/mgsa_ram.sv -----
`timescale 1ns / 1ps

module mgsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mgsa_ctrl.sv -----
`timescale 1ns / 1ps

module mgsa_ctrl
  import mgsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic req_take_i,
  input  logic cfg_we_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN,
    S_RELCHK,
    S_LOC,
    S_WRITE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.res_code = ST_OK;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.word_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg_we_i) begin
          cmd_o.clr_start = 1'b1;
          state_d         = S_CLEAR;
        end else if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = req_take_i ? S_SCAN : S_RELCHK;
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.word_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.none) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_code  = ST_FULL;
          state_d         = S_IDLE;
        end else begin
          cmd_o.loc_start = 1'b1;
          state_d         = S_LOC;
        end
      end
      S_RELCHK: begin
        if (sts_i.rel_bad) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_code  = ST_BAD_REL;
          state_d         = S_IDLE;
        end else begin
          cmd_o.loc_start = 1'b1;
          state_d         = S_LOC;
        end
      end
      S_LOC: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.res_valid = 1'b1;
        if (sts_i.is_take || sts_i.bit_set) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.res_code = ST_OK;
        end else begin
          cmd_o.res_code = ST_BAD_REL;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- rtl/core/mgsa_datapath.sv -----
`timescale 1ns / 1ps

module mgsa_datapath
  import mgsa_pkg::*;
#(
  parameter int MAX_SLOTS = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  req_t            req_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  output res_t            res_o,
  output logic            done_o
);

  localparam int MapWords = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW       = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int PW       = $clog2(MAX_SLOTS);
  localparam int NW       = PW + 1;
  localparam int LW       = $clog2(WORD_BITS);
  localparam int DW       = (PW > LW) ? PW : LW;
  localparam int EW       = (NW > CfgW) ? NW : CfgW;
  localparam int TreeN    = 1 << LW;

  typedef struct packed {
    logic          v;
    logic [LW-1:0] d;
    logic [LW-1:0] p;
  } node_t;

  logic [CfgW-1:0] room_q;
  req_t            req_q;
  logic [AW-1:0]   wcnt_q;
  logic [PW-1:0]   base_q;

  logic            v0_q;
  logic [PW-1:0]   b0_q;
  logic            vA_q;
  logic [PW-1:0]   bA_q;
  node_t           candA_q [TreeN];
  logic [LW-1:0]   fA_q;
  logic [LW-1:0]   lA_q;
  logic            anyA_q;
  logic            vB_q;
  logic [PW-1:0]   bB_q;
  node_t           bwB_q;
  logic [LW-1:0]   fB_q;
  logic [LW-1:0]   lB_q;
  logic            anyB_q;

  logic            have_q;
  logic [PW-1:0]   prev_q;
  logic            found_q, found_d;
  logic [DW-1:0]   bestd_q, bestd_d;
  logic [PW-1:0]   bestp_q, bestp_d;

  logic [PW-1:0]   pos_q;
  res_t            res_q;
  logic            done_q;

  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] bit_mask;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic                 we;

  logic [EW-1:0] room_ext;
  logic [NW-1:0] n;
  logic [PW-1:0] nm1;
  logic [LW-1:0] lb;
  logic [AW-1:0] pos_word;

  node_t         cand [TreeN];
  logic [LW-1:0] first_bit;
  logic [LW-1:0] last_bit;
  node_t         tree [1:2*TreeN-1];

  logic [PW-1:0] cur;
  logic [PW-1:0] gap;
  logic [NW-1:0] pair_sum;
  logic          xv;
  logic [DW-1:0] xd;
  logic [PW-1:0] xp;
  logic [DW-1:0] wd;
  logic [PW-1:0] wp;

  logic          endv;
  logic [DW-1:0] endd;
  logic          end_better;
  logic [PW-1:0] fin_pos;

  mgsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MapWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    room_ext = EW'(room_q);
    if (room_ext == '0) begin
      n = NW'(1);
    end else if (room_ext > EW'(MAX_SLOTS)) begin
      n = NW'(MAX_SLOTS);
    end else begin
      n = NW'(room_ext);
    end
    nm1 = PW'(n - NW'(1));
  end

  assign lb       = LW'(pos_q);
  assign pos_word = AW'(pos_q >> LW);
  assign bit_mask = WORD_BITS'(1) << lb;
  assign raddr    = cmd_i.scan_issue ? wcnt_q : pos_word;
  assign we       = cmd_i.clr_step | cmd_i.wr_en;
  assign waddr    = cmd_i.clr_step ? wcnt_q : pos_word;

  always_comb begin
    if (cmd_i.clr_step) begin
      wdata = '0;
    end else if (req_q.req_type == REQ_TAKE) begin
      wdata = rdata | bit_mask;
    end else begin
      wdata = rdata & ~bit_mask;
    end
  end

  // Each occupied bit looks back to the nearest occupied bit of the same word.
  always_comb begin
    int   jj;
    logic jv;
    for (int i = 0; i < WORD_BITS; i++) begin
      jv = 1'b0;
      jj = 0;
      for (int j = 0; j < i; j++) begin
        if (rdata[j]) begin
          jv = 1'b1;
          jj = j;
        end
      end
      cand[i].v = rdata[i] && jv && ((i - jj) >= 2);
      cand[i].d = LW'((i - jj) >> 1);
      cand[i].p = LW'((i + jj) >> 1);
    end
    for (int i = WORD_BITS; i < TreeN; i++) begin
      cand[i] = '0;
    end
    first_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (rdata[i]) begin
        first_bit = LW'(i);
      end
    end
    last_bit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (rdata[i]) begin
        last_bit = LW'(i);
      end
    end
  end

  // The lower half wins a tie, so the lowest slot is kept.
  always_comb begin
    for (int k = 0; k < TreeN; k++) begin
      tree[TreeN + k] = candA_q[k];
    end
    for (int k = TreeN - 1; k >= 1; k--) begin
      if (tree[2*k].v && (!tree[2*k+1].v || tree[2*k].d >= tree[2*k+1].d)) begin
        tree[k] = tree[2*k];
      end else begin
        tree[k] = tree[2*k+1];
      end
    end
  end

  always_comb begin
    cur      = bB_q + PW'(fB_q);
    gap      = cur - prev_q;
    pair_sum = {1'b0, cur} + {1'b0, prev_q};
    if (have_q) begin
      xv = ({1'b0, gap} >= NW'(2));
      xd = DW'(gap >> 1);
      xp = PW'(pair_sum >> 1);
    end else begin
      xv = (cur != '0);
      xd = DW'(cur);
      xp = '0;
    end
    wd = DW'(bwB_q.d);
    wp = bB_q + PW'(bwB_q.p);

    found_d = found_q;
    bestd_d = bestd_q;
    bestp_d = bestp_q;
    if (anyB_q && xv && (!found_d || xd > bestd_d)) begin
      found_d = 1'b1;
      bestd_d = xd;
      bestp_d = xp;
    end
    if (bwB_q.v && (!found_d || wd > bestd_d)) begin
      found_d = 1'b1;
      bestd_d = wd;
      bestp_d = wp;
    end
  end

  always_comb begin
    endv       = have_q && (prev_q < nm1);
    endd       = DW'(nm1 - prev_q);
    end_better = endv && (!found_q || endd > bestd_q);
    if (!have_q) begin
      fin_pos = '0;
    end else if (end_better) begin
      fin_pos = nm1;
    end else begin
      fin_pos = bestp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q  <= RoomReset;
      wcnt_q  <= '0;
      v0_q    <= 1'b0;
      vA_q    <= 1'b0;
      vB_q    <= 1'b0;
      have_q  <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        room_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_start || cmd_i.accept) begin
        wcnt_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.scan_issue) begin
        wcnt_q <= wcnt_q + AW'(1);
      end
      v0_q <= cmd_i.scan_issue;
      vA_q <= v0_q;
      vB_q <= vA_q;
      if (cmd_i.accept) begin
        have_q  <= 1'b0;
        found_q <= 1'b0;
      end else if (vB_q) begin
        found_q <= found_d;
        if (anyB_q) begin
          have_q <= 1'b1;
        end
      end
      done_q <= cmd_i.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q  <= req_i;
      base_q <= '0;
    end else if (cmd_i.scan_issue) begin
      base_q <= base_q + PW'(WORD_BITS);
    end
    b0_q    <= base_q;
    bA_q    <= b0_q;
    candA_q <= cand;
    fA_q    <= first_bit;
    lA_q    <= last_bit;
    anyA_q  <= |rdata;
    bB_q    <= bA_q;
    bwB_q   <= tree[1];
    fB_q    <= fA_q;
    lB_q    <= lA_q;
    anyB_q  <= anyA_q;
    if (vB_q) begin
      bestd_q <= bestd_d;
      bestp_q <= bestp_d;
      if (anyB_q) begin
        prev_q <= bB_q + PW'(lB_q);
      end
    end
    if (cmd_i.loc_start) begin
      if (req_q.req_type == REQ_TAKE) begin
        pos_q <= fin_pos;
      end else begin
        pos_q <= PW'(req_q.slot_index);
      end
    end
    if (cmd_i.res_valid) begin
      res_q.status <= cmd_i.res_code;
      if (cmd_i.res_code == ST_FULL) begin
        res_q.given_slot <= '0;
      end else if (req_q.req_type == REQ_TAKE) begin
        res_q.given_slot <= IdxW'(pos_q);
      end else begin
        res_q.given_slot <= req_q.slot_index;
      end
    end
  end

  assign sts_o.word_last  = (wcnt_q == AW'(MapWords - 1));
  assign sts_o.pipe_empty = !v0_q && !vA_q && !vB_q;
  assign sts_o.none       = have_q && !found_q && !endv;
  assign sts_o.rel_bad    = (EW'(req_q.slot_index) >= EW'(n));
  assign sts_o.bit_set    = rdata[lb];
  assign sts_o.is_take    = (req_q.req_type == REQ_TAKE);

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// ----- rtl/core/max_gap_seat_allocator_top.sv -----
`timescale 1ns / 1ps

// Slot allocator for a row of up to MAX_SLOTS slots, kept as a bitmap of WORD_BITS-wide words
// in a single RAM. WORD_BITS must be a power of two; the block does not check it. An item
// is taken when start is high and busy and cfg_we_i are low; its one result appears on
// res_o for exactly one cycle with done_o high, and the receiver cannot stall it. A take
// streams the map through a three-stage gap pipeline at one word per cycle, lets it drain,
// then reads the chosen word once more to set its bit; a full row gives ST_FULL once the
// pipeline drains. A release reads the slot's word and clears its bit; a release of a slot
// beyond the row, or of a free slot, gives ST_BAD_REL. After reset and after every room_size
// write made while idle, the block clears the map with busy high before it takes an item.

module max_gap_seat_allocator_top
  import mgsa_pkg::*;
#(
  parameter int MAX_SLOTS = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  req_t            req_i,
  output logic            done_o,
  output res_t            res_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  mgsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_take_i (req_i.req_type == REQ_TAKE),
    .cfg_we_i   (cfg_we_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  mgsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .done_o      (done_o)
  );

  // Every result closes an item that kept the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result without a pending item");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("block still busy after its result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cfg_we_i) |=> busy)
    else $error("accepted item did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_FULL) |-> (res_o.given_slot == '0))
    else $error("full row reported a nonzero slot");

endmodule
